// ----- design/kst_pkg.sv -----
package kst_pkg;

    // default sizing of the keymap
    localparam int NUM_CODES_DEF    = 128;
    localparam int SPECIAL_BASE_DEF = 256;
    localparam int NUM_BANKS        = 5;
    localparam int ENTRY_W          = 9;

    // operation codes carried in tuser
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_WRITE     = 2'd1;
    localparam logic [1:0] OP_CLEAR     = 2'd2;
    localparam logic [1:0] OP_CHAR      = 2'd3;

    // translate result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_CODE   = 2'd1;
    localparam logic [1:0] KIND_ACTION = 2'd2;

    // actions
    localparam logic [3:0] ACT_SHUTDOWN = 4'd0;
    localparam logic [3:0] ACT_CAPS     = 4'd13;
    localparam logic [3:0] ACT_NUM      = 4'd14;
    localparam logic [3:0] ACT_SCROLL   = 4'd15;

    // keymap banks
    localparam logic [2:0] BANK_NORMAL      = 3'd0;
    localparam logic [2:0] BANK_SHIFT       = 3'd1;
    localparam logic [2:0] BANK_ALTGR       = 3'd2;
    localparam logic [2:0] BANK_ALTGR_SHIFT = 3'd3;
    localparam logic [2:0] BANK_CTRL        = 3'd4;

    // modifier byte masks
    localparam logic [7:0] MOD_CTRL  = 8'h11;
    localparam logic [7:0] MOD_SHIFT = 8'h22;
    localparam logic [7:0] MOD_ALT   = 8'h04;
    localparam logic [7:0] MOD_WIN   = 8'h88;
    localparam logic [7:0] MOD_ALTGR = 8'h40;

    // physical code ranges
    localparam logic [7:0] KEYPAD_LO = 8'h53;
    localparam logic [7:0] KEYPAD_HI = 8'h63;
    localparam logic [7:0] LETTER_LO = 8'h04;
    localparam logic [7:0] LETTER_HI = 8'h1D;

    // character constants
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] LETTER_SPAN  = 8'd25;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [8:0] CHAR_MIN_EXCL = 9'd32;

    // special key offsets from the space key
    localparam int SPC_DELETE = 10;
    localparam int SPC_F1     = 23;
    localparam int SPC_F12    = 34;
    localparam int SPC_CAPS   = 36;
    localparam int SPC_SCROLL = 38;
    localparam int SPC_NUM    = 40;
    localparam int SPC_COUNT  = 59;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_NORM  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_CLEAR = 4'b1000
    } state_t;

endpackage

// ----- design/kst_ram.sv -----
module kst_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 640
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/keyboard_scan_code_translator_unit.sv -----
// keyboard keymap translator: one request per transfer on the s_ side (op in s_tuser), one
// result per request on the m_ side; the keymap lives in a single-port-write, registered-read
// ram of NUM_BANKS*NUM_CODES entries (bank-major), and its contents are undefined after reset,
// so load entries before translating; translate reads bank 0, then the selected bank, except
// for alt combinations decided by bank 0 alone, and an invalid physical code is answered
// without a read; write entry and character conversion are answered straight from the request;
// a bank clear writes one entry per cycle; a new request is taken only when the block is idle
// and the output register is free or being drained, and a result is held in that register
// until m_tready
module keyboard_scan_code_translator_unit
    import kst_pkg::*;
#(
    parameter int NUM_CODES    = NUM_CODES_DEF,
    parameter int SPECIAL_BASE = SPECIAL_BASE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // phys_code[7:0], modifiers[15:8], bank_sel[18:16], entry_value[27:19],
    // key_code[36:28], zero fill [39:37]
    input  logic [39:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // status[0], out_code[9:1], action[13:10], char_valid[14], char_out[22:15],
    // special_valid[23], special_index[29:24], led_status[32:30], zero fill [39:33]
    output logic [39:0] m_tdata,
    // kind[1:0]
    output logic [1:0]  m_tuser
);

    localparam int DEPTH  = NUM_CODES * NUM_BANKS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(NUM_CODES);

    // logical key codes of interest
    localparam logic [9:0] KEY_LIMIT = 10'(SPECIAL_BASE + SPC_COUNT);
    localparam logic [8:0] KEY_SPACE = 9'(SPECIAL_BASE);
    localparam logic [8:0] KEY_DEL   = 9'(SPECIAL_BASE + SPC_DELETE);
    localparam logic [8:0] KEY_F1    = 9'(SPECIAL_BASE + SPC_F1);
    localparam logic [8:0] KEY_F12   = 9'(SPECIAL_BASE + SPC_F12);
    localparam logic [8:0] KEY_CAPS  = 9'(SPECIAL_BASE + SPC_CAPS);
    localparam logic [8:0] KEY_SCRL  = 9'(SPECIAL_BASE + SPC_SCROLL);
    localparam logic [8:0] KEY_NUM   = 9'(SPECIAL_BASE + SPC_NUM);

    function automatic logic [ADDR_W-1:0] tbl_addr(input logic [2:0] bank,
                                                   input logic [7:0] code);
        return ADDR_W'(bank) * ADDR_W'(NUM_CODES) + ADDR_W'(code);
    endfunction

    // request fields
    logic [1:0]  in_op;
    logic [7:0]  in_phys;
    logic [7:0]  in_mods;
    logic [2:0]  in_bank;
    logic [8:0]  in_value;
    logic [8:0]  in_key;

    assign in_op    = s_tuser;
    assign in_phys  = s_tdata[7:0];
    assign in_mods  = s_tdata[15:8];
    assign in_bank  = s_tdata[18:16];
    assign in_value = s_tdata[27:19];
    assign in_key   = s_tdata[36:28];

    state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             caps_reg, caps_next;
    logic             num_reg, num_next;
    logic             scrl_reg, scrl_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // request held for multi-cycle ops
    logic [7:0] phys_reg;
    logic [7:0] mods_reg;
    logic [2:0] bank_reg;

    logic [39:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    // ram ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [8:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [8:0]        ram_rdata;

    kst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic out_free;
    logic accept;
    logic in_phys_ok;
    logic in_bank_ok;

    assign out_free   = !m_tvalid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign accept     = s_tvalid && s_tready;
    assign in_phys_ok = (in_phys != 8'd0) && (9'(in_phys) < 9'(NUM_CODES));
    assign in_bank_ok = (in_bank < 3'(NUM_BANKS));

    // bank chosen for the second lookup
    logic [2:0] tab_bank;
    logic       keypad;
    logic       letter;

    assign keypad = (phys_reg >= KEYPAD_LO) && (phys_reg <= KEYPAD_HI);
    assign letter = (phys_reg >= LETTER_LO) && (phys_reg <= LETTER_HI);

    always_comb
    begin
        tab_bank = BANK_NORMAL;
        if (keypad)
        begin
            if (num_reg)
            begin
                tab_bank = BANK_SHIFT;
            end
        end
        else if ((mods_reg & MOD_ALTGR) != 8'd0)
        begin
            tab_bank = ((mods_reg & MOD_SHIFT) != 8'd0) ? BANK_ALTGR_SHIFT : BANK_ALTGR;
        end
        else if ((mods_reg & MOD_SHIFT) != 8'd0)
        begin
            tab_bank = BANK_SHIFT;
        end
        else if (((mods_reg & MOD_CTRL) != 8'd0) && !letter)
        begin
            tab_bank = BANK_CTRL;
        end
    end

    // character conversion, done straight from the request
    logic       chr_valid;
    logic [7:0] chr_out;
    logic       spc_valid;
    logic [5:0] spc_index;
    logic [7:0] chr_raw;
    logic [7:0] chr_ctrl;

    assign chr_raw  = in_key[7:0];
    assign chr_ctrl = chr_raw - CHAR_LOWER_A;

    always_comb
    begin
        chr_valid = 1'b0;
        chr_out   = 8'd0;
        spc_valid = 1'b0;
        spc_index = 6'd0;
        if ((in_key > CHAR_MIN_EXCL) && (10'(in_key) < KEY_LIMIT))
        begin
            if (in_key >= KEY_SPACE)
            begin
                spc_valid = 1'b1;
                spc_index = 6'(in_key - KEY_SPACE);
            end
            else if ((in_mods & MOD_CTRL) != 8'd0)
            begin
                // ctrl with a lower-case letter maps to 1..26, anything else gives nothing
                if (chr_ctrl <= LETTER_SPAN)
                begin
                    chr_valid = 1'b1;
                    chr_out   = chr_ctrl + 8'd1;
                end
            end
            else
            begin
                chr_valid = 1'b1;
                chr_out   = chr_raw;
                if (caps_reg)
                begin
                    if ((chr_raw >= CHAR_UPPER_A) && (chr_raw <= CHAR_UPPER_Z))
                    begin
                        chr_out = chr_raw + CASE_OFFSET;
                    end
                    else if ((chr_raw >= CHAR_LOWER_A) && (chr_raw <= CHAR_LOWER_Z))
                    begin
                        chr_out = chr_raw - CASE_OFFSET;
                    end
                end
            end
        end
    end

    // decisions on the bank 0 entry
    logic norm_alt;
    logic norm_ctrl;
    logic norm_is_del;
    logic norm_is_fkey;

    assign norm_alt     = (mods_reg & MOD_ALT) != 8'd0;
    assign norm_ctrl    = (mods_reg & MOD_CTRL) != 8'd0;
    assign norm_is_del  = (ram_rdata == KEY_DEL);
    assign norm_is_fkey = (ram_rdata >= KEY_F1) && (ram_rdata <= KEY_F12);

    // result fields
    logic       out_load;
    logic       res_status;
    logic [1:0] res_kind;
    logic [8:0] res_code;
    logic [3:0] res_action;
    logic       res_cv;
    logic [7:0] res_ch;
    logic       res_sv;
    logic [5:0] res_sidx;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        caps_next  = caps_reg;
        num_next   = num_reg;
        scrl_next  = scrl_reg;

        ram_we    = 1'b0;
        ram_waddr = tbl_addr(in_bank, in_phys);
        ram_wdata = in_value;
        ram_re    = 1'b0;
        ram_raddr = tbl_addr(BANK_NORMAL, in_phys);

        out_load   = 1'b0;
        res_status = 1'b0;
        res_kind   = KIND_NONE;
        res_code   = 9'd0;
        res_action = ACT_SHUTDOWN;
        res_cv     = 1'b0;
        res_ch     = 8'd0;
        res_sv     = 1'b0;
        res_sidx   = 6'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_TRANSLATE:
                        begin
                            if (in_phys_ok)
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_NORM;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        OP_WRITE:
                        begin
                            out_load = 1'b1;
                            if (in_bank_ok && in_phys_ok && (10'(in_value) < KEY_LIMIT))
                            begin
                                ram_we = 1'b1;
                            end
                            else
                            begin
                                res_status = 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            if (in_bank_ok)
                            begin
                                cnt_next   = '0;
                                state_next = ST_CLEAR;
                            end
                            else
                            begin
                                out_load   = 1'b1;
                                res_status = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_load = 1'b1;
                            res_cv   = chr_valid;
                            res_ch   = chr_out;
                            res_sv   = spc_valid;
                            res_sidx = spc_index;
                        end
                    endcase
                end
            end
            ST_NORM:
            begin
                // bank 0 entry is on the ram output
                if (norm_is_del && norm_ctrl && norm_alt)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        res_kind   = KIND_ACTION;
                        res_action = ACT_SHUTDOWN;
                        state_next = ST_IDLE;
                    end
                end
                else if (norm_is_fkey && norm_alt)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        res_kind   = KIND_ACTION;
                        res_action = 4'(ram_rdata - KEY_F1) + 4'd1;
                        state_next = ST_IDLE;
                    end
                end
                else if ((mods_reg & (MOD_ALT | MOD_WIN)) != 8'd0)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = tbl_addr(tab_bank, phys_reg);
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (ram_rdata == KEY_CAPS)
                    begin
                        caps_next  = !caps_reg;
                        res_kind   = KIND_ACTION;
                        res_action = ACT_CAPS;
                    end
                    else if (ram_rdata == KEY_NUM)
                    begin
                        num_next   = !num_reg;
                        res_kind   = KIND_ACTION;
                        res_action = ACT_NUM;
                    end
                    else if (ram_rdata == KEY_SCRL)
                    begin
                        scrl_next  = !scrl_reg;
                        res_kind   = KIND_ACTION;
                        res_action = ACT_SCROLL;
                    end
                    else if (ram_rdata != 9'd0)
                    begin
                        res_kind = KIND_CODE;
                        res_code = ram_rdata;
                    end
                end
            end
            ST_CLEAR:
            begin
                // one entry per cycle, the last one repeats until the result can go out
                ram_we    = 1'b1;
                ram_waddr = tbl_addr(bank_reg, 8'(cnt_reg));
                ram_wdata = 9'd0;
                if (cnt_reg == CNT_W'(NUM_CODES - 1))
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            caps_reg     <= 1'b0;
            num_reg      <= 1'b0;
            scrl_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            caps_reg     <= caps_next;
            num_reg      <= num_next;
            scrl_reg     <= scrl_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            phys_reg <= in_phys;
            mods_reg <= in_mods;
            bank_reg <= in_bank;
        end
        if (out_load)
        begin
            m_tuser_reg <= res_kind;
            m_tdata_reg <= {7'd0, scrl_next, caps_next, num_next, res_sidx, res_sv,
                            res_ch, res_cv, res_action, res_code, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- tb/sv/keyboard_scan_code_translator_unit_tb.sv -----
`timescale 1ns / 1ps

module keyboard_scan_code_translator_unit_tb;
    import kst_pkg::*;

    // block sizing as built with its default parameters
    localparam int NUM_CODES    = NUM_CODES_DEF;
    localparam int SPECIAL_BASE = SPECIAL_BASE_DEF;
    localparam int KEY_LIMIT    = SPECIAL_BASE + SPC_COUNT;

    // one request as it travels on the s_ side
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] phys_code;
        logic [7:0] modifiers;
        logic [2:0] bank_sel;
        logic [8:0] entry_value;
        logic [8:0] key_code;
    } keymap_req_t;

    // one result as it travels on the m_ side
    typedef struct packed {
        logic       status;
        logic [1:0] kind;
        logic [8:0] out_code;
        logic [3:0] action;
        logic       char_valid;
        logic [7:0] char_out;
        logic       special_valid;
        logic [5:0] special_index;
        logic [2:0] led_status;
    } keymap_res_t;

    // keymap and lock flags mirrored from the accepted requests, plus the results
    // still owed by the block in transfer order
    class keymap_scoreboard;
        logic [ENTRY_W-1:0] keymap [NUM_BANKS][NUM_CODES];
        logic               caps_lock;
        logic               num_lock;
        logic               scroll_lock;
        keymap_res_t        pending_results [$];
        int unsigned        errors;

        function new();
            caps_lock   = 1'b0;
            num_lock    = 1'b0;
            scroll_lock = 1'b0;
            errors      = 0;
        endfunction

        // work out what the block answers to one request and update the mirror
        function keymap_res_t apply_request(keymap_req_t r);
            keymap_res_t res;
            logic [8:0]  norm;
            logic [8:0]  lc;
            logic [2:0]  bank;
            logic [7:0]  c;
            logic [7:0]  d;
            int          i;
            res = '0;
            case (r.op)
                OP_TRANSLATE:
                begin
                    if (r.phys_code != 0 && r.phys_code < NUM_CODES) begin
                        norm = keymap[BANK_NORMAL][r.phys_code];
                        if (norm == SPECIAL_BASE + SPC_DELETE && (r.modifiers & MOD_CTRL) != 0
                            && (r.modifiers & MOD_ALT) != 0) begin
                            res.kind   = KIND_ACTION;
                            res.action = ACT_SHUTDOWN;
                        end else if (norm >= SPECIAL_BASE + SPC_F1 && norm <= SPECIAL_BASE + SPC_F12
                                     && (r.modifiers & MOD_ALT) != 0) begin
                            res.kind   = KIND_ACTION;
                            res.action = 4'(1 + int'(norm) - (SPECIAL_BASE + SPC_F1));
                        end else if ((r.modifiers & (MOD_ALT | MOD_WIN)) == 0) begin
                            bank = BANK_NORMAL;
                            if (r.phys_code >= KEYPAD_LO && r.phys_code <= KEYPAD_HI) begin
                                if (num_lock)
                                    bank = BANK_SHIFT;
                            end else if ((r.modifiers & MOD_ALTGR) != 0) begin
                                bank = ((r.modifiers & MOD_SHIFT) != 0) ? BANK_ALTGR_SHIFT
                                                                        : BANK_ALTGR;
                            end else if ((r.modifiers & MOD_SHIFT) != 0) begin
                                bank = BANK_SHIFT;
                            end else if ((r.modifiers & MOD_CTRL) != 0
                                         && (r.phys_code < LETTER_LO || r.phys_code > LETTER_HI)) begin
                                bank = BANK_CTRL;
                            end
                            lc = keymap[bank][r.phys_code];
                            if (lc == SPECIAL_BASE + SPC_CAPS) begin
                                caps_lock  = !caps_lock;
                                res.kind   = KIND_ACTION;
                                res.action = ACT_CAPS;
                            end else if (lc == SPECIAL_BASE + SPC_NUM) begin
                                num_lock   = !num_lock;
                                res.kind   = KIND_ACTION;
                                res.action = ACT_NUM;
                            end else if (lc == SPECIAL_BASE + SPC_SCROLL) begin
                                scroll_lock = !scroll_lock;
                                res.kind    = KIND_ACTION;
                                res.action  = ACT_SCROLL;
                            end else if (lc != 0) begin
                                res.kind     = KIND_CODE;
                                res.out_code = lc;
                            end
                        end
                    end
                end
                OP_WRITE:
                begin
                    if (r.bank_sel >= NUM_BANKS || r.phys_code == 0 || r.phys_code >= NUM_CODES
                        || r.entry_value >= KEY_LIMIT)
                        res.status = 1'b1;
                    else
                        keymap[r.bank_sel][r.phys_code] = r.entry_value;
                end
                OP_CLEAR:
                begin
                    if (r.bank_sel >= NUM_BANKS)
                        res.status = 1'b1;
                    else
                        for (i = 0; i < NUM_CODES; i++)
                            keymap[r.bank_sel][i] = '0;
                end
                default:
                begin
                    if (r.key_code > CHAR_MIN_EXCL && r.key_code < KEY_LIMIT) begin
                        if (r.key_code >= SPECIAL_BASE) begin
                            res.special_valid = 1'b1;
                            res.special_index = 6'(int'(r.key_code) - SPECIAL_BASE);
                        end else begin
                            c = r.key_code[7:0];
                            if ((r.modifiers & MOD_CTRL) != 0) begin
                                // only lower-case letters have a control character
                                d = c - CHAR_LOWER_A;
                                if (d <= LETTER_SPAN) begin
                                    res.char_valid = 1'b1;
                                    res.char_out   = d + 8'd1;
                                end
                            end else begin
                                if (caps_lock) begin
                                    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                                        c = c + CASE_OFFSET;
                                    else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
                                        c = c - CASE_OFFSET;
                                end
                                res.char_valid = 1'b1;
                                res.char_out   = c;
                            end
                        end
                    end
                end
            endcase
            res.led_status = {scroll_lock, caps_lock, num_lock};
            return res;
        endfunction

        function void note_request(keymap_req_t r);
            pending_results.push_back(apply_request(r));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [39:0] data, logic [1:0] user);
            keymap_res_t want;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing outstanding: tdata 0x%0h tuser %0d",
                       data, user);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("status", want.status, data[0]);
            compare_field("kind", want.kind, user);
            compare_field("out_code", want.out_code, data[9:1]);
            compare_field("action", want.action, data[13:10]);
            compare_field("char_valid", want.char_valid, data[14]);
            compare_field("char_out", want.char_out, data[22:15]);
            compare_field("special_valid", want.special_valid, data[23]);
            compare_field("special_index", want.special_index, data[29:24]);
            compare_field("led_status", want.led_status, data[32:30]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // phys_code[7:0], modifiers[15:8], bank_sel[18:16], entry_value[27:19],
    // key_code[36:28], zero fill [39:37]
    logic [39:0] s_tdata;
    // op[1:0]
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // status[0], out_code[9:1], action[13:10], char_valid[14], char_out[22:15],
    // special_valid[23], special_index[29:24], led_status[32:30], zero fill [39:33]
    logic [39:0] m_tdata;
    // kind[1:0]
    logic [1:0]  m_tuser;

    keymap_scoreboard board;

    // idle odds in percent per cycle, changed from one phase to the next
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    // physical codes that most random traffic lands on, so writes and lookups
    // meet; range edges of the letter and keypad groups are among them
    logic [7:0] hot_codes [16] = '{8'h04, 8'h1D, 8'h03, 8'h1E, 8'h53, 8'h63, 8'h52, 8'h64,
                                   8'h28, 8'h3A, 8'h45, 8'h7F, 8'h01, 8'h10, 8'h58, 8'h60};

    keyboard_scan_code_translator_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // generous ceiling on simulation time
    initial
    begin
        #2_000_000;
        $display("keyboard_scan_code_translator_unit test failed");
        $finish;
    end

    // result side: random backpressure, and every transfer checked against the
    // oldest outstanding prediction; values read here are the ones before the edge
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser);
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one request, with an optional idle gap first, and hold it until taken
    task automatic send_request(input keymap_req_t r);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {3'b000, r.key_code, r.entry_value, r.bank_sel, r.modifiers, r.phys_code};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(r);
    endtask

    task automatic send_fields(input logic [1:0] op, input logic [7:0] phys,
                               input logic [7:0] mods, input logic [2:0] bank,
                               input logic [8:0] value, input logic [8:0] kc);
        keymap_req_t r;
        r.op          = op;
        r.phys_code   = phys;
        r.modifiers   = mods;
        r.bank_sel    = bank;
        r.entry_value = value;
        r.key_code    = kc;
        send_request(r);
    endtask

    // physical code: mostly the hot set, some anywhere valid, some invalid
    function automatic logic [7:0] pick_phys();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll <= 6)
            return hot_codes[$urandom_range(15)];
        else if (roll <= 8)
            return 8'($urandom_range(NUM_CODES - 1, 1));
        else if ($urandom_range(3) == 0)
            return 8'd0;
        else
            return 8'($urandom_range(255, NUM_CODES));
    endfunction

    // modifiers: none, one key, two keys or anything
    function automatic logic [7:0] pick_mods();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'h01 << $urandom_range(7);
            2: return (8'h01 << $urandom_range(7)) | (8'h01 << $urandom_range(7));
            default: return 8'($urandom);
        endcase
    endfunction

    // random request with every field filled, then the fields the op uses shaped
    function automatic keymap_req_t random_request();
        keymap_req_t r;
        int unsigned roll;
        r      = keymap_req_t'({$urandom, $urandom});
        roll   = $urandom_range(99);
        r.op   = (roll < 40) ? OP_TRANSLATE : (roll < 70) ? OP_WRITE :
                 (roll < 97) ? OP_CHAR : OP_CLEAR;
        case (r.op)
            OP_TRANSLATE:
            begin
                r.phys_code = pick_phys();
                r.modifiers = pick_mods();
            end
            OP_WRITE:
            begin
                r.phys_code = pick_phys();
                r.bank_sel  = ($urandom_range(9) == 0) ? 3'($urandom_range(7, NUM_BANKS))
                                                       : 3'($urandom_range(NUM_BANKS - 1));
                case ($urandom_range(9))
                    // keys the translator treats specially
                    0: r.entry_value = 9'(SPECIAL_BASE + SPC_DELETE);
                    1: r.entry_value = 9'(SPECIAL_BASE + $urandom_range(SPC_F12, SPC_F1));
                    2: r.entry_value = 9'(SPECIAL_BASE + SPC_CAPS);
                    3: r.entry_value = ($urandom_range(1) == 0) ? 9'(SPECIAL_BASE + SPC_NUM)
                                                                : 9'(SPECIAL_BASE + SPC_SCROLL);
                    8: r.entry_value = 9'd0;
                    // out of range, rejected
                    9: r.entry_value = 9'($urandom_range(511, KEY_LIMIT));
                    default: r.entry_value = 9'($urandom_range(KEY_LIMIT - 1, 1));
                endcase
            end
            OP_CLEAR:
            begin
                r.bank_sel = ($urandom_range(6) == 0) ? 3'($urandom_range(7, NUM_BANKS))
                                                      : 3'($urandom_range(NUM_BANKS - 1));
            end
            default:
            begin
                r.modifiers = pick_mods();
                case ($urandom_range(3))
                    0: r.key_code = 9'($urandom_range(40));
                    1: r.key_code = 9'($urandom_range(CHAR_LOWER_Z, CHAR_UPPER_A));
                    2: r.key_code = 9'($urandom_range(511, SPECIAL_BASE));
                    default: r.key_code = 9'($urandom);
                endcase
            end
        endcase
        return r;
    endfunction

    initial
    begin
        int phase;
        int n;
        board          = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_TRANSLATE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // clearing every bank first leaves no entry undefined
        send_fields(OP_CLEAR, 8'h00, 8'h00, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_CLEAR, 8'h00, 8'h00, BANK_SHIFT, 9'd0, 9'd0);
        send_fields(OP_CLEAR, 8'h00, 8'h00, BANK_ALTGR, 9'd0, 9'd0);
        send_fields(OP_CLEAR, 8'h00, 8'h00, BANK_ALTGR_SHIFT, 9'd0, 9'd0);
        send_fields(OP_CLEAR, 8'h00, 8'h00, BANK_CTRL, 9'd0, 9'd0);
        // bad bank on clear and write, invalid code, value past the last key
        send_fields(OP_CLEAR, 8'h00, 8'h00, 3'd7, 9'd0, 9'd0);
        send_fields(OP_WRITE, 8'h10, 8'h00, 3'd5, 9'd65, 9'd0);
        send_fields(OP_WRITE, 8'hFF, 8'h00, BANK_NORMAL, 9'd65, 9'd0);
        send_fields(OP_WRITE, 8'h10, 8'h00, BANK_NORMAL, 9'(KEY_LIMIT), 9'd0);
        // load the keys that trigger actions, the highest code and the highest value
        send_fields(OP_WRITE, 8'h4C, 8'h00, BANK_NORMAL, 9'(SPECIAL_BASE + SPC_DELETE), 9'd0);
        send_fields(OP_WRITE, 8'h3A, 8'h00, BANK_NORMAL, 9'(SPECIAL_BASE + SPC_F1), 9'd0);
        send_fields(OP_WRITE, 8'h45, 8'h00, BANK_NORMAL, 9'(SPECIAL_BASE + SPC_F12), 9'd0);
        send_fields(OP_WRITE, 8'h39, 8'h00, BANK_NORMAL, 9'(SPECIAL_BASE + SPC_CAPS), 9'd0);
        send_fields(OP_WRITE, 8'h53, 8'h00, BANK_NORMAL, 9'(SPECIAL_BASE + SPC_NUM), 9'd0);
        send_fields(OP_WRITE, 8'h47, 8'h00, BANK_NORMAL, 9'(SPECIAL_BASE + SPC_SCROLL), 9'd0);
        send_fields(OP_WRITE, 8'h63, 8'h00, BANK_SHIFT, 9'(KEY_LIMIT - 1), 9'd0);
        send_fields(OP_WRITE, 8'h7F, 8'h00, BANK_CTRL, 9'h041, 9'd0);
        // ctrl+alt+delete, alt+f1, alt+f12, win alone, then the three lock toggles
        send_fields(OP_TRANSLATE, 8'h4C, 8'h05, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h3A, MOD_ALT, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h45, MOD_ALT, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h04, 8'h08, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h39, 8'h00, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h53, 8'h00, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h47, 8'h00, BANK_NORMAL, 9'd0, 9'd0);
        // keypad under num lock, right ctrl on a non-letter, invalid codes at both ends
        send_fields(OP_TRANSLATE, 8'h63, 8'h00, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h7F, 8'h10, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h00, 8'h00, BANK_NORMAL, 9'd0, 9'd0);
        send_fields(OP_TRANSLATE, 8'h80, 8'h00, BANK_NORMAL, 9'd0, 9'd0);
        // characters: space bound, lowest printable, caps swap, ctrl letter,
        // ctrl on an upper-case letter, highest special, first invalid code
        send_fields(OP_CHAR, 8'h00, 8'h00, BANK_NORMAL, 9'd0, 9'd32);
        send_fields(OP_CHAR, 8'h00, 8'h00, BANK_NORMAL, 9'd0, 9'd33);
        send_fields(OP_CHAR, 8'h00, 8'h00, BANK_NORMAL, 9'd0, 9'h061);
        send_fields(OP_CHAR, 8'h00, 8'h01, BANK_NORMAL, 9'd0, 9'h07A);
        send_fields(OP_CHAR, 8'h00, 8'h10, BANK_NORMAL, 9'd0, 9'h041);
        send_fields(OP_CHAR, 8'h00, 8'h00, BANK_NORMAL, 9'd0, 9'(KEY_LIMIT - 1));
        send_fields(OP_CHAR, 8'h00, 8'h00, BANK_NORMAL, 9'd0, 9'(KEY_LIMIT));

        // random traffic in four idling phases
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 59;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            for (n = 0; n < 475; n++)
                send_request(random_request());
        end
        s_tvalid <= 1'b0;

        // drain, then wait quietly for anything stray
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("keyboard_scan_code_translator_unit test passed");
        else
            $display("keyboard_scan_code_translator_unit test failed");
        $finish;
    end

endmodule
